/* rtl/core/att_pkg.sv */
`timescale 1ns / 1ps
package att_pkg;
    localparam int AngleFracBits = 8;
    localparam int CordicStages  = 16;
    localparam int TblFrac       = 24;
    localparam int InGuard       = 12;
    localparam int SumW          = 33;
    localparam int RadW          = 58;
    localparam int RootW         = 29;
    localparam int CordW         = 34;
    localparam int ZW            = 33;

    localparam logic [1:0] FUNC_ROLL  = 2'd1;
    localparam logic [1:0] FUNC_PITCH = 2'd2;

    localparam logic [ZW-1:0] DEG90 = ZW'(64'd90 << TblFrac);

    function automatic logic [ZW-1:0] atan_tbl(input int i);
        logic [ZW-1:0] t;
        begin
            case (i)
                0: t = ZW'(754974720);
                1: t = ZW'(445687602);
                2: t = ZW'(235489088);
                3: t = ZW'(119537938);
                4: t = ZW'(60000934);
                5: t = ZW'(30029717);
                6: t = ZW'(15018523);
                7: t = ZW'(7509720);
                8: t = ZW'(3754917);
                9: t = ZW'(1877466);
                10: t = ZW'(938734);
                11: t = ZW'(469367);
                12: t = ZW'(234684);
                13: t = ZW'(117342);
                14: t = ZW'(58671);
                15: t = ZW'(29335);
                16: t = ZW'(14668);
                17: t = ZW'(7334);
                18: t = ZW'(3667);
                19: t = ZW'(1833);
                20: t = ZW'(917);
                21: t = ZW'(458);
                22: t = ZW'(229);
                default: t = ZW'(115);
            endcase
            return t;
        end
    endfunction

    typedef struct packed {
        logic           vld;
        logic           zero_out;
        logic           neg;
        logic           mag_zero;
        logic [15:0]    mag;
    } t_ctl;
endpackage

/* rtl/core/accel_tilt_angle.sv */
`timescale 1ns / 1ps
// Tilt angle pipeline: one sample accepted per cycle while not stalled. Stages
// in order: squares, sum, 29 root digits, CORDIC load, 16 CORDIC stages and
// round into the output register. The two square lanes, the digit-per-stage
// root and the unrolled CORDIC make up that pipe.
// The whole pipe advances when the output is not held by stall.
module accel_tilt_angle (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_func,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_tilt_angle
);
    import att_pkg::*;

    localparam int Sh = TblFrac - AngleFracBits;

    logic en;
    assign en = !(o_valid && i_stall);
    assign o_stall = !en;

    // stage 0: select, square in lanes
    logic signed [15:0] sel_a, sel_b, sel_n;
    logic [31:0] sq_a, sq_b;
    t_ctl r_c0, r_c1, n_c0;
    logic [15:0] r_n0, r_n1;
    always_comb begin
        sel_a = i_accel_x;
        sel_b = i_accel_z;
        sel_n = i_accel_y;
        if (i_func == FUNC_PITCH) begin
            sel_a = i_accel_y;
            sel_n = i_accel_x;
        end
        n_c0.vld = i_valid;
        n_c0.zero_out = !(i_func == FUNC_ROLL || i_func == FUNC_PITCH);
        n_c0.neg = sel_n[15];
        n_c0.mag = sel_n[15] ? 16'(-sel_n) : sel_n;
        n_c0.mag_zero = (sel_n == 16'sd0);
    end
    att_square_lane u_sqa (.i_clk, .i_en(en), .i_val(sel_a), .o_sq(sq_a));
    att_square_lane u_sqb (.i_clk, .i_en(en), .i_val(sel_b), .o_sq(sq_b));
    logic [SumW-1:0] r_sum;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0.vld <= 1'b0;
            r_c1.vld <= 1'b0;
        end else if (en) begin
            r_c0 <= n_c0;
            r_c1 <= r_c0;
        end
        if (en) begin
            r_n0 <= n_c0.mag;
            r_n1 <= r_n0;
            r_sum <= SumW'(sq_a) + SumW'(sq_b);
        end
    end

    // root stages
    logic [RadW-1:0]  s_rad  [RootW+1];
    logic [RootW+1:0] s_rem  [RootW+1];
    logic [RootW-1:0] s_root [RootW+1];
    t_ctl             s_ctl  [RootW+1];
    logic [15:0]      s_num  [RootW+1];
    assign s_rad[0] = {1'b0, r_sum, 24'd0};
    assign s_rem[0] = '0;
    assign s_root[0] = '0;
    assign s_ctl[0] = r_c1;
    assign s_num[0] = r_n1;
    for (genvar g = 0; g < RootW; g++) begin : g_sq
        logic [RootW-1:0] root_v;
        att_sqrt_stage u_st (
            .i_clk, .i_en(en),
            .i_rad(s_rad[g]), .i_rem(s_rem[g]), .i_root(s_root[g]),
            .i_ctl(g == 0 ? r_c1 : s_ctl[g]), .i_num(s_num[g]),
            .o_rad(s_rad[g+1]), .o_rem(s_rem[g+1]), .o_root(root_v),
            .o_ctl(s_ctl[g+1]), .o_num(s_num[g+1])
        );
        assign s_root[g+1] = root_v;
    end

    // CORDIC load; vld kept under reset separately
    logic [RootW:0] vld_sr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) vld_sr <= '0;
        else if (en) vld_sr <= {vld_sr[RootW-1:0], r_c1.vld};
    end

    logic signed [CordW-1:0] c_x [CordicStages+1];
    logic signed [CordW-1:0] c_y [CordicStages+1];
    logic signed [ZW:0]      c_z [CordicStages+1];
    t_ctl                    c_c [CordicStages+1];
    logic                    r_den_zero;
    logic [CordicStages-1:0] dz_sr;
    always_ff @(posedge i_clk) begin
        if (en) begin
            c_x[0] <= CordW'(s_root[RootW]);
            c_y[0] <= CordW'({s_num[RootW], 12'd0});
            c_z[0] <= '0;
            c_c[0] <= s_ctl[RootW];
            r_den_zero <= (s_root[RootW] == '0);
            dz_sr <= {dz_sr[CordicStages-2:0], r_den_zero};
        end
    end
    for (genvar k = 0; k < CordicStages; k++) begin : g_cd
        att_cordic_stage u_cs (
            .i_clk, .i_en(en), .i_idx(5'(k)),
            .i_x(c_x[k]), .i_y(c_y[k]), .i_z(c_z[k]), .i_ctl(c_c[k]),
            .o_x(c_x[k+1]), .o_y(c_y[k+1]), .o_z(c_z[k+1]), .o_ctl(c_c[k+1])
        );
    end

    // clamp, round, sign; denominator-zero flag is aligned with the CORDIC output
    logic [ZW-1:0] zc;
    logic [ZW:0]   rnd;
    logic [15:0]   mag_o;
    t_ctl          fc;
    logic [CordicStages-1:0] vld_c;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) vld_c <= '0;
        else if (en) vld_c <= {vld_c[CordicStages-2:0], vld_sr[RootW]};
    end
    always_comb begin
        fc = c_c[CordicStages];
        if (dz_sr[CordicStages-1]) zc = DEG90;
        else if (c_z[CordicStages] < 0) zc = '0;
        else if (c_z[CordicStages] > $signed({1'b0, DEG90})) zc = DEG90;
        else zc = c_z[CordicStages][ZW-1:0];
        if (fc.mag_zero) zc = '0;
        rnd = ({1'b0, zc} + (ZW+1)'(1 << (Sh - 1))) >> Sh;
        mag_o = (rnd > (ZW+1)'(32767)) ? 16'd32767 : rnd[15:0];
    end
    logic signed [15:0] r_out;
    logic r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= 1'b0;
        else if (en) r_vld <= vld_c[CordicStages-1];
        if (en) begin
            if (fc.zero_out) r_out <= '0;
            else r_out <= fc.neg ? 16'(-mag_o) : mag_o;
        end
    end
    assign o_valid = r_vld;
    assign o_tilt_angle = r_out;
endmodule

/* rtl/core/att_square_lane.sv */
`timescale 1ns / 1ps
module att_square_lane (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_val,
    output logic        [31:0] o_sq
);
    logic [31:0] r_sq;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= 32'(i_val * i_val);
        end
    end
    assign o_sq = r_sq;
endmodule

/* rtl/core/att_sqrt_stage.sv */
`timescale 1ns / 1ps
// One restoring step of the root: two radicand bits in, one root bit out.
module att_sqrt_stage (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [att_pkg::RadW-1:0]    i_rad,
    input  logic [att_pkg::RootW+1:0]   i_rem,
    input  logic [att_pkg::RootW-1:0]   i_root,
    input  att_pkg::t_ctl               i_ctl,
    input  logic [15:0]                 i_num,
    output logic [att_pkg::RadW-1:0]    o_rad,
    output logic [att_pkg::RootW+1:0]   o_rem,
    output logic [att_pkg::RootW-1:0]   o_root,
    output att_pkg::t_ctl               o_ctl,
    output logic [15:0]                 o_num
);
    import att_pkg::*;

    logic [RootW+1:0] trial, rem_sh;
    logic [RadW-1:0]  r_rad;
    logic [RootW+1:0] r_rem;
    logic [RootW-1:0] r_root;
    t_ctl             r_ctl;
    logic [15:0]      r_num;
    always_comb begin
        rem_sh = {i_rem[RootW-1:0], i_rad[RadW-1 -: 2]};
        trial  = {i_root, 2'b01};
    end
    always_ff @(posedge i_clk) begin
        if (!i_en) begin
        end else begin
            r_rad <= {i_rad[RadW-3:0], 2'b00};
            r_ctl <= i_ctl;
            r_num <= i_num;
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {i_root[RootW-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {i_root[RootW-2:0], 1'b0};
            end
        end
    end
    assign o_rad = r_rad;
    assign o_rem = r_rem;
    assign o_root = r_root;
    assign o_ctl = r_ctl;
    assign o_num = r_num;
endmodule

/* rtl/core/att_cordic_stage.sv */
`timescale 1ns / 1ps
module att_cordic_stage (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [4:0]                       i_idx,
    input  logic signed [att_pkg::CordW-1:0] i_x,
    input  logic signed [att_pkg::CordW-1:0] i_y,
    input  logic signed [att_pkg::ZW:0]      i_z,
    input  att_pkg::t_ctl                    i_ctl,
    output logic signed [att_pkg::CordW-1:0] o_x,
    output logic signed [att_pkg::CordW-1:0] o_y,
    output logic signed [att_pkg::ZW:0]      o_z,
    output att_pkg::t_ctl                    o_ctl
);
    import att_pkg::*;

    logic signed [CordW-1:0] r_x, r_y;
    logic signed [ZW:0]      r_z;
    t_ctl                    r_ctl;
    logic signed [ZW:0]      ang;
    assign ang = $signed({1'b0, atan_tbl(int'(i_idx))});
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl <= i_ctl;
            if (i_y >= 0) begin
                r_x <= i_x + (i_y >>> i_idx);
                r_y <= i_y - (i_x >>> i_idx);
                r_z <= i_z + ang;
            end else begin
                r_x <= i_x - (i_y >>> i_idx);
                r_y <= i_y + (i_x >>> i_idx);
                r_z <= i_z - ang;
            end
        end
    end
    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
    assign o_ctl = r_ctl;
endmodule

/* tb/sv/accel_tilt_angle_chk.sv */
`timescale 1ns / 1ps
module accel_tilt_angle_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic [1:0]         i_func,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic signed [15:0] o_tilt_angle,
    output int                 fail_count,
    output int                 angles_pending
);
    import att_pkg::*;

    localparam int SHIFT_OUT = 24 - AngleFracBits;

    // atan(2^-i) in degrees, Q24
    localparam longint ATAN_DEG [24] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    logic signed [15:0] angle_q[$];

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [15:0] tilt_of(logic [1:0] f, logic signed [15:0] ax,
                                                  logic signed [15:0] ay,
                                                  logic signed [15:0] az);
        longint num, a, b, mag, xc, yc, zc, xs, ys, r;
        longint unsigned den;
        if (f == FUNC_ROLL) begin
            num = ay; a = ax; b = az;
        end else if (f == FUNC_PITCH) begin
            num = ax; a = ay; b = az;
        end else begin
            return 16'sd0;
        end
        den = floor_root(64'(a * a + b * b) << (2 * InGuard));
        mag = (num < 0) ? -num : num;
        zc  = 0;
        if (mag != 0) begin
            if (den == 0) begin
                zc = 64'd90 << 24;
            end else begin
                xc = longint'(den);
                yc = mag << InGuard;
                for (int i = 0; i < CordicStages && i < 24; i++) begin
                    xs = xc >>> i;
                    ys = yc >>> i;
                    if (yc >= 0) begin
                        xc += ys; yc -= xs; zc += ATAN_DEG[i];
                    end else begin
                        xc -= ys; yc += xs; zc -= ATAN_DEG[i];
                    end
                end
                if (zc < 0) zc = 0;
                if (zc > (64'd90 << 24)) zc = 64'd90 << 24;
            end
        end
        r = (zc + (64'd1 << (SHIFT_OUT - 1))) >> SHIFT_OUT;
        if (num < 0) r = -r;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return 16'(r);
    endfunction

    initial begin
        fail_count = 0;
        angles_pending = 0;
    end

    always @(posedge i_clk) begin
        logic signed [15:0] want;
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                angle_q.push_back(tilt_of(i_func, i_accel_x, i_accel_y, i_accel_z));
            if (o_valid && !i_stall) begin
                if (angle_q.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected angle %0d", o_tilt_angle);
                end else begin
                    want = angle_q.pop_front();
                    if (want !== o_tilt_angle) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("tilt_angle mismatch: expected %0d got %0d",
                                     want, o_tilt_angle);
                    end
                end
            end
            angles_pending <= angle_q.size();
        end
    end
endmodule

/* tb/sv/accel_tilt_angle_tb.sv */
`timescale 1ns / 1ps
module accel_tilt_angle_tb;
    import att_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_func;
    logic signed [15:0] i_accel_x, i_accel_y, i_accel_z;
    logic               o_valid;
    logic               i_stall;
    logic signed [15:0] o_tilt_angle;
    int                 fail_count;
    int                 angles_pending;
    int                 idle_cycles;
    int                 cycle_no;

    accel_tilt_angle dut (.*);

    accel_tilt_angle_chk chk (.*);

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [15:0] axis_val();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 15)) - 16'd8;
            4: return 16'($urandom_range(0, 511)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(logic [1:0] f, logic [15:0] x, logic [15:0] y, logic [15:0] z);
        int g;
        i_valid   <= 1'b1;
        i_func    <= f;
        i_accel_x <= x;
        i_accel_y <= y;
        i_accel_z <= z;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // receiver side: short and long holds, quiet stretches, one long hold-off
    initial begin
        int n;
        bit pressed;
        pressed = 0;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            n = $urandom_range(0, 99);
            if (!pressed && cycle_no > 1500) begin
                pressed = 1;
                i_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
            end else if (n < 60) begin
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end else if (n < 95) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b1;
                repeat ($urandom_range(20, 80)) @(posedge i_clk);
            end
        end
    end

    // watchdog: cycles with no item moving on either side
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 20000) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [1:0] f;
        cycle_no    = 0;
        idle_cycles = 0;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_func    = '0;
        i_accel_x = '0;
        i_accel_y = '0;
        i_accel_z = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // selector other values, extremes, zero denominator, all zero
        send_item(2'd0, 16'h7fff, 16'h7fff, 16'h7fff);
        send_item(2'd3, 16'h8000, 16'h8000, 16'h8000);
        send_item(FUNC_ROLL, 16'h0000, 16'h0000, 16'h0000);
        send_item(FUNC_PITCH, 16'h0000, 16'h0000, 16'h0000);
        send_item(FUNC_ROLL, 16'h0000, 16'h7fff, 16'h0000);
        send_item(FUNC_ROLL, 16'h0000, 16'h8000, 16'h0000);
        send_item(FUNC_PITCH, 16'h0001, 16'h0000, 16'h0000);
        send_item(FUNC_PITCH, 16'hffff, 16'h0000, 16'h0000);
        send_item(FUNC_ROLL, 16'h8000, 16'h8000, 16'h8000);
        send_item(FUNC_PITCH, 16'h8000, 16'h8000, 16'h8000);
        send_item(FUNC_ROLL, 16'h7fff, 16'h7fff, 16'h7fff);
        send_item(FUNC_PITCH, 16'h7fff, 16'h7fff, 16'h7fff);
        send_item(FUNC_ROLL, 16'h8000, 16'h0001, 16'h8000);
        send_item(FUNC_PITCH, 16'h0001, 16'h7fff, 16'h8000);
        send_item(FUNC_ROLL, 16'h0000, 16'h0000, 16'h4000);
        send_item(FUNC_ROLL, 16'h0000, 16'h4000, 16'h4000);
        send_item(FUNC_PITCH, 16'hc000, 16'h0000, 16'h4000);
        send_item(FUNC_ROLL, 16'h0001, 16'h7fff, 16'h0000);
        send_item(FUNC_PITCH, 16'h8000, 16'h0000, 16'h0001);
        send_item(FUNC_ROLL, 16'h0000, 16'h5555, 16'haaaa);

        for (int k = 0; k < 1600; k++) begin
            f = (($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3))
                                              : 2'($urandom_range(1, 2)));
            send_item(f, axis_val(), axis_val(), axis_val());
        end
        i_valid <= 1'b0;

        while (angles_pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && angles_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

/* filelist.f */
rtl/core/att_pkg.sv
rtl/core/att_square_lane.sv
rtl/core/att_sqrt_stage.sv
rtl/core/att_cordic_stage.sv
rtl/core/accel_tilt_angle.sv
tb/sv/accel_tilt_angle_chk.sv
tb/sv/accel_tilt_angle_tb.sv
